@@ design/igcd_pkg.sv @@
`default_nettype none

package igcd_pkg;

  // Fixed field widths of the stream and configuration ports
  localparam int unsigned PIX_IN_W   = 16;
  localparam int unsigned GRAD_W     = 18;
  localparam int unsigned ROW_IDX_W  = 10;
  localparam int unsigned COL_W      = 16;
  localparam int unsigned ROWS_REG_W = 11;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - 2 * GRAD_W - ROW_IDX_W - COL_W;

  // Register reset values
  localparam logic [ROWS_REG_W-1:0] ROWS_RST = 11'd256;
  localparam logic [COL_W-1:0]      COLS_RST = 16'd256;

  // Item kind carried on tuser
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_e;

  // Position and edge flags of the pixel whose result an item completes
  typedef struct packed {
    logic                 produce;
    logic                 first_row;
    logic                 last_row;
    logic                 first_col;
    logic                 last_col;
    logic                 last;
    logic [ROW_IDX_W-1:0] row;
    logic [COL_W-1:0]     col;
  } meta_t;

endpackage

`default_nettype wire

@@ design/igcd_ram.sv @@
`default_nettype none

module igcd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port; read returns the old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/igcd_scan.sv @@
`default_nettype none

module igcd_scan #(
  parameter int unsigned MAX_ROWS   = 1024,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [igcd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_op_i,
  input  wire logic [igcd_pkg::PIX_IN_W-1:0]   in_pixel_i,
  output logic                                 in_ready_o,
  input  wire logic                            s0_move_i,
  output logic                                 s0_valid_o,
  output igcd_pkg::meta_t                      s0_meta_o,
  output logic      [igcd_pkg::PIX_IN_W-1:0]   s0_pix_o,
  output logic      [igcd_pkg::PIX_IN_W-1:0]   s0_up_o,
  output logic      [igcd_pkg::PIX_IN_W-1:0]   s0_back_o
);

  import igcd_pkg::*;

  localparam int unsigned PW = (PIXEL_BITS < PIX_IN_W) ? PIXEL_BITS : PIX_IN_W;
  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned MW = $clog2(MAX_ROWS + 1);
  localparam int unsigned TW = MW + 1;
  localparam int unsigned CW = (MW > ROWS_REG_W) ? MW : ROWS_REG_W;
  localparam int unsigned A2 = $clog2(2 * MAX_ROWS);

  logic [ROWS_REG_W-1:0] rows_q, rows_d;
  logic [COL_W-1:0]      cols_q, cols_d;
  logic [RW-1:0]         in_row_q, in_row_d;
  logic [COL_W-1:0]      in_col_q, in_col_d;
  logic [RW-1:0]         out_row_q, out_row_d;
  logic [COL_W-1:0]      out_col_q, out_col_d;
  logic                  flushing_q, flushing_d;
  logic [RW-1:0]         p1_q, p1_d;
  logic [A2-1:0]         p2_q, p2_d;
  logic                  s0_valid_q, s0_valid_d;
  meta_t                 meta_q, meta_d;
  logic [PW-1:0]         pix_q;

  logic [CW-1:0]    rows_ext;
  logic [CW-1:0]    m_full;
  logic [MW-1:0]    m;
  logic [TW-1:0]    two_m;
  logic [COL_W-1:0] n;
  logic [RW-1:0]    row_max;
  logic [COL_W-1:0] col_max;
  logic [RW-1:0]    lim1;
  logic [A2-1:0]    lim2;
  logic             acc;
  logic             adv;
  logic             is_flush;
  logic             produce;
  logic             frame_end;
  logic [PW-1:0]    ram1_rd;
  logic [PW-1:0]    ram2_rd;

  // Effective frame size, saturated to the legal range
  always_comb begin
    rows_ext = CW'(rows_q);
    if (rows_ext < CW'(2)) begin
      m_full = CW'(2);
    end else if (rows_ext > CW'(MAX_ROWS)) begin
      m_full = CW'(MAX_ROWS);
    end else begin
      m_full = rows_ext;
    end
  end

  assign m       = MW'(m_full);
  assign two_m   = {m, 1'b0};
  assign n       = (cols_q < COL_W'(2)) ? COL_W'(2) : cols_q;
  assign row_max = RW'(m - MW'(1));
  assign col_max = n - COL_W'(1);
  assign lim1    = RW'(m - MW'(2));
  assign lim2    = A2'(two_m - TW'(1));

  // Input handshake: a transfer advances the scan unless it is dropped
  assign in_ready_o = !s0_valid_q || s0_move_i;
  assign acc        = in_valid_i && in_ready_o;
  assign is_flush   = (op_e'(in_op_i) == OP_FLUSH);
  assign adv        = acc && (is_flush ? flushing_q : !flushing_q);
  assign produce    = is_flush || (in_col_q != '0);
  assign frame_end  = produce && (out_row_q == row_max) && (out_col_q == col_max);

  // Result position and edge flags
  always_comb begin
    meta_d           = meta_q;
    meta_d.produce   = produce;
    meta_d.first_row = (out_row_q == '0);
    meta_d.last_row  = (out_row_q == row_max);
    meta_d.first_col = (out_col_q == '0);
    meta_d.last_col  = (out_col_q == col_max);
    meta_d.last      = frame_end;
    meta_d.row       = ROW_IDX_W'(out_row_q);
    meta_d.col       = out_col_q;
  end

  // Scan counters, line pointers and configuration
  always_comb begin
    rows_d     = rows_q;
    cols_d     = cols_q;
    in_row_d   = in_row_q;
    in_col_d   = in_col_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    flushing_d = flushing_q;
    p1_d       = p1_q;
    p2_d       = p2_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ROWS: rows_d = cfg_data_i[ROWS_REG_W-1:0];
        REG_COLS: cols_d = cfg_data_i;
        default:  rows_d = rows_q;
      endcase
      in_row_d   = '0;
      in_col_d   = '0;
      out_row_d  = '0;
      out_col_d  = '0;
      flushing_d = 1'b0;
      p1_d       = '0;
      p2_d       = '0;
    end else if (adv) begin
      p1_d = (p1_q == lim1) ? '0 : p1_q + RW'(1);
      p2_d = (p2_q == lim2) ? '0 : p2_q + A2'(1);
      if (!is_flush) begin
        if (in_row_q == row_max) begin
          in_row_d = '0;
          in_col_d = in_col_q + COL_W'(1);
          if (in_col_q == col_max) begin
            flushing_d = 1'b1;
          end
        end else begin
          in_row_d = in_row_q + RW'(1);
        end
      end
      if (produce) begin
        if (out_row_q == row_max) begin
          out_row_d = '0;
          out_col_d = out_col_q + COL_W'(1);
        end else begin
          out_row_d = out_row_q + RW'(1);
        end
      end
      // frame complete: the scan counters, flush state and line pointers start over
      if (frame_end) begin
        in_row_d   = '0;
        in_col_d   = '0;
        out_row_d  = '0;
        out_col_d  = '0;
        flushing_d = 1'b0;
        p1_d       = '0;
        p2_d       = '0;
      end
    end
  end

  // Input stage occupancy
  always_comb begin
    if (adv) begin
      s0_valid_d = 1'b1;
    end else if (s0_move_i) begin
      s0_valid_d = 1'b0;
    end else begin
      s0_valid_d = s0_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q     <= ROWS_RST;
      cols_q     <= COLS_RST;
      in_row_q   <= '0;
      in_col_q   <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      flushing_q <= 1'b0;
      p1_q       <= '0;
      p2_q       <= '0;
      s0_valid_q <= 1'b0;
    end else begin
      rows_q     <= rows_d;
      cols_q     <= cols_d;
      in_row_q   <= in_row_d;
      in_col_q   <= in_col_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      flushing_q <= flushing_d;
      p1_q       <= p1_d;
      p2_q       <= p2_d;
      s0_valid_q <= s0_valid_d;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta_q <= meta_d;
      pix_q  <= in_pixel_i[PW-1:0];
    end
  end

  // Line delay of rows-1 items: gives the pixel below the centre
  igcd_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_ROWS)
  ) u_line_near (
    .clk_i   (clk_i),
    .we_i    (adv),
    .waddr_i (p1_q),
    .wdata_i (in_pixel_i[PW-1:0]),
    .re_i    (adv),
    .raddr_i (p1_q),
    .rdata_o (ram1_rd)
  );

  // Line delay of 2*rows items: gives the pixel one column to the left
  igcd_ram #(
    .WIDTH (PW),
    .DEPTH (2 * MAX_ROWS)
  ) u_line_far (
    .clk_i   (clk_i),
    .we_i    (adv),
    .waddr_i (p2_q),
    .wdata_i (in_pixel_i[PW-1:0]),
    .re_i    (adv),
    .raddr_i (p2_q),
    .rdata_o (ram2_rd)
  );

  assign s0_valid_o = s0_valid_q;
  assign s0_meta_o  = meta_q;
  assign s0_pix_o   = PIX_IN_W'(pix_q);
  assign s0_up_o    = PIX_IN_W'(ram1_rd);
  assign s0_back_o  = PIX_IN_W'(ram2_rd);

endmodule

`default_nettype wire

@@ design/igcd_grad.sv @@
`default_nettype none

module igcd_grad (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s0_valid_i,
  input  wire igcd_pkg::meta_t                 s0_meta_i,
  input  wire logic [igcd_pkg::PIX_IN_W-1:0]   s0_pix_i,
  input  wire logic [igcd_pkg::PIX_IN_W-1:0]   s0_up_i,
  input  wire logic [igcd_pkg::PIX_IN_W-1:0]   s0_back_i,
  output logic                                 s0_move_o,
  output logic                                 m_valid_o,
  input  wire logic                            m_ready_i,
  output logic      [igcd_pkg::OUT_DATA_W-1:0] m_data_o,
  output logic                                 m_last_o
);

  import igcd_pkg::*;

  // Difference in half units; a one-sided difference is doubled
  function automatic logic signed [GRAD_W-1:0] half_diff(
    input logic [PIX_IN_W-1:0] a,
    input logic [PIX_IN_W-1:0] b,
    input logic                dbl
  );
    logic signed [GRAD_W-1:0] d;
    d = GRAD_W'(a) - GRAD_W'(b);
    return dbl ? (d <<< 1) : d;
  endfunction

  logic [PIX_IN_W-1:0]      ctr_q;
  logic [PIX_IN_W-1:0]      above_q;
  logic                     m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0]    m_data_q;
  logic                     m_last_q;
  logic                     load;
  logic signed [GRAD_W-1:0] grad_col;
  logic signed [GRAD_W-1:0] grad_row;

  assign s0_move_o = s0_valid_i && (!m_valid_q || m_ready_i);
  assign load      = s0_move_o && s0_meta_i.produce;

  // Column direction: right neighbour is the newest pixel, left one from the far line
  always_comb begin
    if (s0_meta_i.first_col) begin
      grad_col = half_diff(s0_pix_i, ctr_q, 1'b1);
    end else if (s0_meta_i.last_col) begin
      grad_col = half_diff(ctr_q, s0_back_i, 1'b1);
    end else begin
      grad_col = half_diff(s0_pix_i, s0_back_i, 1'b0);
    end
  end

  // Row direction: neighbours from the near line and the tap behind the centre
  always_comb begin
    if (s0_meta_i.first_row) begin
      grad_row = half_diff(s0_up_i, ctr_q, 1'b1);
    end else if (s0_meta_i.last_row) begin
      grad_row = half_diff(ctr_q, above_q, 1'b1);
    end else begin
      grad_row = half_diff(s0_up_i, above_q, 1'b0);
    end
  end

  // Neighbour taps along the column
  always_ff @(posedge clk_i) begin
    if (s0_move_o) begin
      ctr_q   <= s0_up_i;
      above_q <= ctr_q;
    end
  end

  // Output register
  always_comb begin
    if (load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_data_q <= {{OUT_PAD_W{1'b0}}, s0_meta_i.col, s0_meta_i.row, grad_row, grad_col};
      m_last_q <= s0_meta_i.last;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_last_o  = m_last_q;

endmodule

`default_nettype wire

@@ design/image_gradient_central_difference.sv @@
// Path: the pixel that completes a result goes through the input and output
//   registers; a pixel's result follows the pixel one column to its right.
// Throughput: one item per cycle unless stalled, set by each line RAM's single
//   write/read port; the output register admits an item while a result waits.
// Reset: asynchronous, active low; frame counters and valids clear, rows and
//   cols return to 256; line RAM contents are not cleared.
`default_nettype none

module image_gradient_central_difference #(
  parameter int unsigned MAX_ROWS   = 1024,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [igcd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [15:0] pixel
  input  wire logic [igcd_pkg::PIX_IN_W-1:0]   s_axis_tdata,
  // [0] op
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [17:0] grad_col, [35:18] grad_row, [45:36] row_index, [61:46] col_index
  output logic      [igcd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                                 m_axis_tlast
);

  import igcd_pkg::*;

  logic                s0_valid;
  logic                s0_move;
  meta_t               s0_meta;
  logic [PIX_IN_W-1:0] s0_pix;
  logic [PIX_IN_W-1:0] s0_up;
  logic [PIX_IN_W-1:0] s0_back;

  // Scan position, line RAMs and input register
  igcd_scan #(
    .MAX_ROWS   (MAX_ROWS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_pixel_i (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .s0_move_i  (s0_move),
    .s0_valid_o (s0_valid),
    .s0_meta_o  (s0_meta),
    .s0_pix_o   (s0_pix),
    .s0_up_o    (s0_up),
    .s0_back_o  (s0_back)
  );

  // Gradient arithmetic and result register
  igcd_grad u_grad (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s0_valid_i (s0_valid),
    .s0_meta_i  (s0_meta),
    .s0_pix_i   (s0_pix),
    .s0_up_i    (s0_up),
    .s0_back_i  (s0_back),
    .s0_move_o  (s0_move),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast)
  );

`ifndef SYNTH
  // An empty output register never holds back the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // End of frame only on a produced corner pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_valid && s0_meta.last |-> s0_meta.produce && s0_meta.last_row && s0_meta.last_col)
    else $error("frame end flagged off the last corner");

  // Frame is at least two by two, so opposite edges never coincide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_valid |-> !(s0_meta.first_row && s0_meta.last_row) &&
                 !(s0_meta.first_col && s0_meta.last_col))
    else $error("first and last edge flagged together");
`endif

endmodule

`default_nettype wire
